### rtl/pidc_pkg.sv
package pidc_pkg;

    // Field widths
    localparam int DATA_W      = 16;   // measurement, setpoint, gains, limits
    localparam int ERR_W       = 17;   // setpoint minus measurement
    localparam int TICK_W      = 32;   // millisecond tick
    localparam int TERM_W      = 32;   // reported P, I and D terms
    localparam int CFG_INDEX_W = 3;

    // Integral arithmetic: step magnitude |error| * elapsed, Q.16 fraction
    localparam int MAG_W       = DATA_W + TICK_W;       // 48
    localparam int FRAC_W      = 16;
    localparam int I_DVD_W     = MAG_W + FRAC_W;        // 64
    localparam int INC_SAT_BIT = 40;                    // step saturates at 2^40
    localparam int ACC_W       = 32;                    // clamped integral fits here

    // Serial multiplier: right operand is a gain or a 16-bit magnitude
    localparam int MUL_B_W     = ERR_W;

    // Default tick rate
    localparam int TPS_DEFAULT = 1000;

endpackage

### rtl/pid_controller_antiwindup_core.sv
// PID controller with anti-windup, fixed point. Each accepted word carries a
// measurement, a setpoint and the millisecond tick; one result word follows with
// the clamped control value, the error and the P, I and D terms. The integral is
// kept in Q.16, clamped to limit_low..limit_high, and the derivative is the change
// in measurement per second (zero when no tick has elapsed). Gains are signed Q8.8.
// One word is processed at a time: between one acceptance and the next lie five
// 17-step multiplications on one shared serial multiplier, one 64-step serial
// division for the integral step (the derivative division runs beside it), and
// the sequencing and sum states. A finished result waits in its output register,
// so the next word may be accepted before the result is taken. Configuration
// writes are taken at any cycle, but are meant to happen only while no word is in
// flight.
module pid_controller_antiwindup_core #(
    parameter int TICKS_PER_SECOND = pidc_pkg::TPS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // sample channel
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic signed [pidc_pkg::DATA_W-1:0]  measured,
    input  logic signed [pidc_pkg::DATA_W-1:0]  setpoint,
    input  logic [pidc_pkg::TICK_W-1:0]         tick_now,
    // result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [pidc_pkg::DATA_W-1:0]  control,
    output logic signed [pidc_pkg::ERR_W-1:0]   error_out,
    output logic signed [pidc_pkg::TERM_W-1:0]  p_term,
    output logic signed [pidc_pkg::TERM_W-1:0]  i_term,
    output logic signed [pidc_pkg::TERM_W-1:0]  d_term,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pidc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pidc_pkg::DATA_W-1:0]         cfg_data
);

    import pidc_pkg::*;

    // Derived widths
    localparam int TPS_W    = $clog2(TICKS_PER_SECOND + 1);
    localparam int DM_W     = DATA_W + TPS_W;            // |diff| * ticks per second
    localparam int DERIV_W  = DM_W + 1;
    localparam int A_W      = (TICK_W + 1 > DERIV_W) ? TICK_W + 1 : DERIV_W;
    localparam int B_W      = MUL_B_W;
    localparam int P_W      = A_W + B_W;
    localparam int PPROD_W  = DATA_W + ERR_W;
    localparam int IPROD_W  = DATA_W + ACC_W;
    localparam int DPROD_W  = DATA_W + DERIV_W;
    localparam int SUM_W    = DPROD_W + 2;
    localparam int INC_W    = INC_SAT_BIT + 1;
    localparam int STEP_W   = INC_W + 1;
    localparam int ASUM_W   = STEP_W + 1;
    localparam int SATX_W   = DPROD_W + TERM_W;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_P     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_I     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_D     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT_HIGH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT_LOW  = 3'd4;

    localparam logic signed [DATA_W-1:0] GAIN_P_RST     = 16'sd256;
    localparam logic signed [DATA_W-1:0] LIMIT_HIGH_RST = 16'sd1000;
    localparam logic signed [DATA_W-1:0] LIMIT_LOW_RST  = -16'sd1000;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MAG_GO,  S_MAG_WAIT,
        S_DM_GO,   S_DM_WAIT,
        S_DIV_GO,  S_DIV_WAIT,
        S_ACC,
        S_P_GO,    S_P_WAIT,
        S_I_GO,    S_I_WAIT,
        S_D_GO,    S_D_WAIT,
        S_SUM1,    S_SUM2,
        S_OUT
    } state_t;

    state_t state_reg;

    // Configuration
    logic signed [DATA_W-1:0] gain_p_reg;
    logic signed [DATA_W-1:0] gain_i_reg;
    logic signed [DATA_W-1:0] gain_d_reg;
    logic signed [DATA_W-1:0] limit_high_reg;
    logic signed [DATA_W-1:0] limit_low_reg;

    // Controller state
    logic [TICK_W-1:0]        last_tick_reg;
    logic signed [DATA_W-1:0] last_measured_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // Per-word working registers
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [ERR_W-1:0]   diff_reg;
    logic [TICK_W-1:0]         elapsed_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic [DM_W-1:0]           dm_reg;
    logic signed [DERIV_W-1:0] deriv_reg;
    logic signed [PPROD_W-1:0] pprod_reg;
    logic signed [IPROD_W-1:0] iprod_reg;
    logic signed [DPROD_W-1:0] dprod_reg;
    logic signed [SUM_W-1:0]   sum_reg;

    // Result register
    logic                      result_valid_reg;
    logic signed [DATA_W-1:0]  control_reg;
    logic signed [ERR_W-1:0]   error_reg;
    logic signed [TERM_W-1:0]  p_term_reg;
    logic signed [TERM_W-1:0]  i_term_reg;
    logic signed [TERM_W-1:0]  d_term_reg;

    // Unit handshakes
    logic                  mul_start;
    logic signed [A_W-1:0] mul_a;
    logic signed [B_W-1:0] mul_b;
    logic                  mul_busy;
    logic signed [P_W-1:0] mul_product;
    logic                  div_start;
    logic                  divi_busy;
    logic [I_DVD_W-1:0]    divi_quo;
    logic                  divd_busy;
    logic [DM_W-1:0]       divd_quo;

    logic                  sample_take;
    logic                  result_free;
    logic                  result_load;

    // Combinational datapath values
    logic [ERR_W-1:0]          err_mag;
    logic [ERR_W-1:0]          diff_mag;
    logic                      inc_sat;
    logic [INC_W-1:0]          inc;
    logic signed [STEP_W-1:0]  step;
    logic signed [ASUM_W-1:0]  acc_sum;
    logic signed [ASUM_W-1:0]  acc_hi;
    logic signed [ASUM_W-1:0]  acc_lo;
    logic signed [ACC_W-1:0]   acc_new;
    logic signed [DERIV_W-1:0] deriv_new;
    logic signed [SUM_W-1:0]   ctl_full;
    logic signed [DATA_W-1:0]  ctl_clamped;
    logic signed [SATX_W-1:0]  dsh;
    logic signed [TERM_W-1:0]  d_term_sat;

    assign sample_take = sample_valid && !sample_stall;
    assign result_free = !result_valid_reg || !result_stall;
    assign result_load = (state_reg == S_OUT) && result_free;

    // Magnitudes for the unsigned multiplications
    always_comb
    begin
        err_mag  = err_reg[ERR_W-1]  ? ERR_W'(-err_reg)  : ERR_W'(err_reg);
        diff_mag = diff_reg[ERR_W-1] ? ERR_W'(-diff_reg) : ERR_W'(diff_reg);
    end

    // Shared multiplier operand select
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            S_MAG_GO:
            begin
                mul_start = 1'b1;
                mul_a     = A_W'({1'b0, elapsed_reg});
                mul_b     = B_W'(err_mag);
            end
            S_DM_GO:
            begin
                mul_start = 1'b1;
                mul_a     = A_W'(TICKS_PER_SECOND);
                mul_b     = B_W'(diff_mag);
            end
            S_P_GO:
            begin
                mul_start = 1'b1;
                mul_a     = A_W'(err_reg);
                mul_b     = B_W'(gain_p_reg);
            end
            S_I_GO:
            begin
                mul_start = 1'b1;
                mul_a     = A_W'(acc_reg);
                mul_b     = B_W'(gain_i_reg);
            end
            S_D_GO:
            begin
                mul_start = 1'b1;
                mul_a     = A_W'(deriv_reg);
                mul_b     = B_W'(gain_d_reg);
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    assign div_start = (state_reg == S_DIV_GO);

    // Integral step, saturated at 2^40, signed by the error, then clamped sum
    always_comb
    begin
        inc_sat = |divi_quo[I_DVD_W-1:INC_SAT_BIT];
        inc     = inc_sat ? (INC_W'(1) << INC_SAT_BIT)
                          : {1'b0, divi_quo[INC_SAT_BIT-1:0]};
        step    = err_reg[ERR_W-1] ? -$signed({1'b0, inc}) : $signed({1'b0, inc});
        acc_sum = ASUM_W'(acc_reg) + ASUM_W'(step);
        acc_hi  = ASUM_W'($signed({limit_high_reg, {FRAC_W{1'b0}}}));
        acc_lo  = ASUM_W'($signed({limit_low_reg, {FRAC_W{1'b0}}}));
        priority if (acc_sum > acc_hi)
        begin
            acc_new = ACC_W'(acc_hi);
        end
        else if (acc_sum < acc_lo)
        begin
            acc_new = ACC_W'(acc_lo);
        end
        else
        begin
            acc_new = ACC_W'(acc_sum);
        end
    end

    // Derivative, zero when no time has passed
    always_comb
    begin
        if (elapsed_reg == '0)
        begin
            deriv_new = '0;
        end
        else if (diff_reg[ERR_W-1])
        begin
            deriv_new = -$signed({1'b0, divd_quo});
        end
        else
        begin
            deriv_new = $signed({1'b0, divd_quo});
        end
    end

    // Control value: floor of the Q8.8 sum, clamped (upper test first)
    always_comb
    begin
        ctl_full = sum_reg >>> 8;
        priority if (ctl_full > SUM_W'(limit_high_reg))
        begin
            ctl_clamped = limit_high_reg;
        end
        else if (ctl_full < SUM_W'(limit_low_reg))
        begin
            ctl_clamped = limit_low_reg;
        end
        else
        begin
            ctl_clamped = DATA_W'(ctl_full);
        end
    end

    // D term saturated to 32 bits
    always_comb
    begin
        dsh = SATX_W'(dprod_reg >>> 8);
        if (dsh == SATX_W'($signed(dsh[TERM_W-1:0])))
        begin
            d_term_sat = dsh[TERM_W-1:0];
        end
        else if (dsh[SATX_W-1])
        begin
            d_term_sat = {1'b1, {(TERM_W-1){1'b0}}};
        end
        else
        begin
            d_term_sat = {1'b0, {(TERM_W-1){1'b1}}};
        end
    end

    // Sequencer, state, configuration and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            gain_p_reg        <= GAIN_P_RST;
            gain_i_reg        <= '0;
            gain_d_reg        <= '0;
            limit_high_reg    <= LIMIT_HIGH_RST;
            limit_low_reg     <= LIMIT_LOW_RST;
            last_tick_reg     <= '0;
            last_measured_reg <= '0;
            acc_reg           <= '0;
            err_reg           <= '0;
            diff_reg          <= '0;
            elapsed_reg       <= '0;
            mag_reg           <= '0;
            dm_reg            <= '0;
            deriv_reg         <= '0;
            pprod_reg         <= '0;
            iprod_reg         <= '0;
            dprod_reg         <= '0;
            sum_reg           <= '0;
            result_valid_reg  <= 1'b0;
            control_reg       <= '0;
            error_reg         <= '0;
            p_term_reg        <= '0;
            i_term_reg        <= '0;
            d_term_reg        <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_GAIN_P:     gain_p_reg     <= $signed(cfg_data);
                    CFG_GAIN_I:     gain_i_reg     <= $signed(cfg_data);
                    CFG_GAIN_D:     gain_d_reg     <= $signed(cfg_data);
                    CFG_LIMIT_HIGH: limit_high_reg <= $signed(cfg_data);
                    CFG_LIMIT_LOW:  limit_low_reg  <= $signed(cfg_data);
                    default:
                    begin
                        gain_p_reg <= gain_p_reg;
                    end
                endcase
            end

            // result valid: a new word may replace one taken at the same edge
            if (result_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (sample_take)
                    begin
                        err_reg           <= ERR_W'(setpoint) - ERR_W'(measured);
                        diff_reg          <= ERR_W'(measured) - ERR_W'(last_measured_reg);
                        elapsed_reg       <= tick_now - last_tick_reg;
                        last_tick_reg     <= tick_now;
                        last_measured_reg <= measured;
                        state_reg         <= S_MAG_GO;
                    end
                end
                S_MAG_GO:
                begin
                    state_reg <= S_MAG_WAIT;
                end
                S_MAG_WAIT:
                begin
                    if (!mul_busy)
                    begin
                        mag_reg   <= mul_product[MAG_W-1:0];
                        state_reg <= S_DM_GO;
                    end
                end
                S_DM_GO:
                begin
                    state_reg <= S_DM_WAIT;
                end
                S_DM_WAIT:
                begin
                    if (!mul_busy)
                    begin
                        dm_reg    <= mul_product[DM_W-1:0];
                        state_reg <= S_DIV_GO;
                    end
                end
                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (!divi_busy && !divd_busy)
                    begin
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    acc_reg   <= acc_new;
                    deriv_reg <= deriv_new;
                    state_reg <= S_P_GO;
                end
                S_P_GO:
                begin
                    state_reg <= S_P_WAIT;
                end
                S_P_WAIT:
                begin
                    if (!mul_busy)
                    begin
                        pprod_reg <= mul_product[PPROD_W-1:0];
                        state_reg <= S_I_GO;
                    end
                end
                S_I_GO:
                begin
                    state_reg <= S_I_WAIT;
                end
                S_I_WAIT:
                begin
                    if (!mul_busy)
                    begin
                        iprod_reg <= mul_product[IPROD_W-1:0];
                        state_reg <= S_D_GO;
                    end
                end
                S_D_GO:
                begin
                    state_reg <= S_D_WAIT;
                end
                S_D_WAIT:
                begin
                    if (!mul_busy)
                    begin
                        dprod_reg <= mul_product[DPROD_W-1:0];
                        state_reg <= S_SUM1;
                    end
                end
                S_SUM1:
                begin
                    sum_reg   <= SUM_W'(pprod_reg) + SUM_W'(iprod_reg >>> FRAC_W);
                    state_reg <= S_SUM2;
                end
                S_SUM2:
                begin
                    sum_reg   <= sum_reg + SUM_W'(dprod_reg);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // load the result word once the output register is free
                    if (result_load)
                    begin
                        control_reg      <= ctl_clamped;
                        error_reg        <= err_reg;
                        p_term_reg       <= TERM_W'(pprod_reg >>> 8);
                        i_term_reg       <= TERM_W'(iprod_reg >>> (FRAC_W + 8));
                        d_term_reg       <= d_term_sat;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Shared serial multiplier
    pidc_mul #(
        .A_W (A_W),
        .B_W (B_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .product (mul_product)
    );

    // Integral step: (|error| * elapsed * 2^16) / ticks per second
    pidc_div #(
        .DVD_W (I_DVD_W),
        .DVS_W (TPS_W)
    ) u_div_int (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({mag_reg, {FRAC_W{1'b0}}}),
        .divisor  (TPS_W'(TICKS_PER_SECOND)),
        .busy     (divi_busy),
        .quotient (divi_quo)
    );

    // Derivative: (|diff| * ticks per second) / elapsed
    pidc_div #(
        .DVD_W (DM_W),
        .DVS_W (TICK_W)
    ) u_div_der (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dm_reg),
        .divisor  (elapsed_reg),
        .busy     (divd_busy),
        .quotient (divd_quo)
    );

    assign sample_stall = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign control      = control_reg;
    assign error_out    = error_reg;
    assign p_term       = p_term_reg;
    assign i_term       = i_term_reg;
    assign d_term       = d_term_reg;

endmodule

### rtl/pidc_mul.sv
// Radix-2 serial multiplier, two's complement on both operands.
// Scans b from its LSB, one bit per cycle; the last (sign) bit subtracts.
module pidc_mul #(
    parameter int A_W = pidc_pkg::TICK_W + 1,
    parameter int B_W = pidc_pkg::MUL_B_W
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [A_W-1:0]  a,
    input  logic signed [B_W-1:0]  b,
    output logic                   busy,
    output logic signed [A_W+B_W-1:0] product
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic [CNT_W-1:0]      cnt_reg;
    logic signed [A_W-1:0] a_reg;
    logic signed [A_W:0]   hi_reg;
    logic [B_W-1:0]        lo_reg;

    logic                  last_bit;
    logic signed [A_W+1:0] a_ext;
    logic signed [A_W+1:0] addend;
    logic signed [A_W+1:0] sum;

    // One partial product per cycle
    always_comb
    begin
        last_bit = (cnt_reg == CNT_W'(1));
        a_ext    = (A_W+2)'(a_reg);
        if (!lo_reg[0])
        begin
            addend = '0;
        end
        else if (last_bit)
        begin
            addend = -a_ext;
        end
        else
        begin
            addend = a_ext;
        end
        sum = (A_W+2)'(hi_reg) + addend;
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(B_W);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Product shift register: partial sum on top, multiplier bits shift out below
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy)
        begin
            hi_reg <= sum[A_W+1:1];
            lo_reg <= {sum[0], lo_reg[B_W-1:1]};
        end
    end

    assign busy    = (cnt_reg != '0);
    assign product = $signed({hi_reg[A_W-1:0], lo_reg});

endmodule

### rtl/pidc_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Dividend and divisor must stay stable while busy.
module pidc_div #(
    parameter int DVD_W = pidc_pkg::I_DVD_W,
    parameter int DVS_W = pidc_pkg::TICK_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    // Shift in the next dividend bit, subtract if the divisor fits
    always_comb
    begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        diff  = trial - {1'b0, divisor};
        fits  = (trial >= {1'b0, divisor});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(DVD_W);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Dividend bits leave at the top while quotient bits enter at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy)
        begin
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule
